// ===== src/hcfs_pkg.sv =====
// Shared types and constants for the HSV colour fade sequencer.
// Depends on nothing; every other file refers to it by scoped names.
package hcfs_pkg;

  // Number of interpolation intervals; each target yields FADE_STEPS+1 items
  localparam int FADE_STEPS = 50;
  localparam int STEP_W     = $clog2(FADE_STEPS + 1);

  // Reciprocal of FADE_STEPS for an exact quotient of any 8-bit magnitude
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((1 << RECIP_SHIFT) + FADE_STEPS - 1) / FADE_STEPS);

  localparam logic [STEP_W-1:0] STEPS_L = STEP_W'(FADE_STEPS);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One colour channel of a classified fade: start, direction, size of move
  typedef struct packed {
    logic [7:0] base;
    logic       neg;
    logic [7:0] mag;
    logic [7:0] quo;   // mag / FADE_STEPS
  } chan_t;

  typedef struct packed {
    chan_t hue;
    chan_t sat;
    chan_t val;
  } fade_t;

endpackage

// ===== src/hcfs_front.sv =====
// Front end: keeps the current colour, folds the hue delta and splits each
// channel move into sign, magnitude and quotient. Depends on hcfs_pkg.
module hcfs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        target_hue_i,
  input  logic [7:0]        target_sat_i,
  input  logic [7:0]        target_val_i,
  output hcfs_pkg::fade_t   fade_o
);

  logic [7:0] cur_hue_q, cur_sat_q, cur_val_q;

  // Build one channel from a signed delta
  function automatic hcfs_pkg::chan_t make_chan(logic [7:0] base, logic signed [8:0] delta);
    hcfs_pkg::chan_t c;
    logic [8:0] mag9;
    logic [8 + hcfs_pkg::RECIP_W:0] prod;
    c.base = base;
    c.neg  = delta[8];
    mag9   = delta[8] ? 9'(-delta) : 9'(delta);
    c.mag  = mag9[7:0];
    prod   = (8 + hcfs_pkg::RECIP_W + 1)'(c.mag)
           * (8 + hcfs_pkg::RECIP_W + 1)'(hcfs_pkg::RECIP_MUL);
    c.quo  = prod[hcfs_pkg::RECIP_SHIFT +: 8];
    return c;
  endfunction

  logic [7:0]        dh8;
  logic signed [8:0] dh, ds, dv;

  // Hue takes the shorter way: the 8-bit wrapped difference read as signed
  always_comb begin
    dh8 = target_hue_i - cur_hue_q;
    dh  = $signed({dh8[7], dh8});
    ds  = $signed({1'b0, target_sat_i}) - $signed({1'b0, cur_sat_q});
    dv  = $signed({1'b0, target_val_i}) - $signed({1'b0, cur_val_q});
    fade_o.hue = make_chan(cur_hue_q, dh);
    fade_o.sat = make_chan(cur_sat_q, ds);
    fade_o.val = make_chan(cur_val_q, dv);
  end

  // Adopt the target as current colour once the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_hue_q <= '0;
      cur_sat_q <= '0;
      cur_val_q <= '0;
    end else if (accept_i) begin
      cur_hue_q <= target_hue_i;
      cur_sat_q <= target_sat_i;
      cur_val_q <= target_val_i;
    end
  end

endmodule

// ===== src/hcfs_queue.sv =====
// Short queue of classified fades between front and back.
// Depends on hcfs_pkg for the entry type and depth.
module hcfs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  hcfs_pkg::fade_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            empty_o,
  output hcfs_pkg::fade_t rd_data_o
);

  hcfs_pkg::fade_t               mem_q [hcfs_pkg::QUEUE_DEPTH];
  logic [hcfs_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hcfs_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o    = (cnt_q == hcfs_pkg::QCNT_W'(hcfs_pkg::QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == hcfs_pkg::QPTR_W'(hcfs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == hcfs_pkg::QPTR_W'(hcfs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/hcfs_back.sv =====
// Back end: walks one fade through FADE_STEPS+1 items with a quotient and
// remainder accumulator per channel, into an output register. Depends on hcfs_pkg.
module hcfs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  hcfs_pkg::fade_t q_data_i,
  output logic            q_rd_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [7:0]      step_hue_o,
  output logic [7:0]      step_sat_o,
  output logic [7:0]      step_val_o,
  output logic            last_step_o
);

  localparam int PROD_W = 8 + hcfs_pkg::STEP_W;

  typedef struct packed {
    logic [7:0]                  base;
    logic                        neg;
    logic [7:0]                  quo;
    logic [hcfs_pkg::STEP_W-1:0] rem;
    logic [7:0]                  q_acc;
    logic [hcfs_pkg::STEP_W-1:0] r_acc;
  } run_t;

  // Split magnitude into quotient and remainder, clear accumulators
  function automatic run_t load_run(hcfs_pkg::chan_t c);
    run_t r;
    logic [PROD_W-1:0] left;
    left    = PROD_W'(c.mag) - PROD_W'(c.quo) * PROD_W'(hcfs_pkg::FADE_STEPS);
    r.base  = c.base;
    r.neg   = c.neg;
    r.quo   = c.quo;
    r.rem   = left[hcfs_pkg::STEP_W-1:0];
    r.q_acc = '0;
    r.r_acc = '0;
    return r;
  endfunction

  // Add one more mag/FADE_STEPS, carrying the remainder
  function automatic run_t step_run(run_t r);
    run_t n;
    logic [hcfs_pkg::STEP_W:0] rs;
    n  = r;
    rs = {1'b0, r.r_acc} + {1'b0, r.rem};
    if (rs >= {1'b0, hcfs_pkg::STEPS_L}) begin
      n.r_acc = hcfs_pkg::STEP_W'(rs - {1'b0, hcfs_pkg::STEPS_L});
      n.q_acc = r.q_acc + r.quo + 8'd1;
    end else begin
      n.r_acc = rs[hcfs_pkg::STEP_W-1:0];
      n.q_acc = r.q_acc + r.quo;
    end
    return n;
  endfunction

  function automatic logic [7:0] run_out(run_t r);
    return r.neg ? r.base - r.q_acc : r.base + r.q_acc;
  endfunction

  run_t                        hue_q, sat_q, val_q;
  logic                        busy_q;
  logic [hcfs_pkg::STEP_W-1:0] idx_q;
  logic                        out_vld_q;
  logic [7:0]                  out_hue_q, out_sat_q, out_val_q;
  logic                        out_last_q;
  logic                        advance, at_last, load;

  assign advance = busy_q && (!out_vld_q || pop_i);
  assign at_last = (idx_q == hcfs_pkg::STEPS_L);
  assign load    = !q_empty_i && (!busy_q || (advance && at_last));
  assign q_rd_o  = load;

  // Sequence the run: load, step, finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (advance) begin
      busy_q <= !at_last;
      idx_q  <= idx_q + 1'b1;
    end
  end

  // Accumulators
  always_ff @(posedge clk_i) begin
    if (load) begin
      hue_q <= load_run(q_data_i.hue);
      sat_q <= load_run(q_data_i.sat);
      val_q <= load_run(q_data_i.val);
    end else if (advance) begin
      hue_q <= step_run(hue_q);
      sat_q <= step_run(sat_q);
      val_q <= step_run(val_q);
    end
  end

  // Output register: hold until popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hue_q  <= run_out(hue_q);
      out_sat_q  <= run_out(sat_q);
      out_val_q  <= run_out(val_q);
      out_last_q <= at_last;
    end
  end

  assign empty_o     = !out_vld_q;
  assign step_hue_o  = out_hue_q;
  assign step_sat_o  = out_sat_q;
  assign step_val_o  = out_val_q;
  assign last_step_o = out_last_q;

endmodule

// ===== src/hsv_color_fade_sequencer.sv =====
// HSV colour fade sequencer: top level joining front, queue and back.
// Depends on hcfs_pkg, hcfs_front, hcfs_queue and hcfs_back.
//
// Each pushed target colour produces FADE_STEPS+1 (51) items, one per cycle
// while pop keeps up, running from the previous target (black after reset)
// to the new one; the final item carries last_step and equals the target.
// A fade therefore occupies the back end while the step counter walks the
// per-channel quotient/remainder accumulators; the next target follows
// without a gap. Up to two further targets wait in the queue, so push is
// refused (full high) only when both queue entries are occupied.
// The first item of a target passes the queue entry, the back-end accumulators and the output register.
module hsv_color_fade_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] target_hue_i,
  input  logic [7:0] target_sat_i,
  input  logic [7:0] target_val_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] step_hue_o,
  output logic [7:0] step_sat_o,
  output logic [7:0] step_val_o,
  output logic       last_step_o
);

  hcfs_pkg::fade_t front_fade, head_fade;
  logic            accept, q_empty, q_rd;

  assign accept = push && !full;

  hcfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .target_hue_i (target_hue_i),
    .target_sat_i (target_sat_i),
    .target_val_i (target_val_i),
    .fade_o       (front_fade)
  );

  hcfs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_fade),
    .full_o    (full),
    .rd_i      (q_rd),
    .empty_o   (q_empty),
    .rd_data_o (head_fade)
  );

  hcfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (head_fade),
    .q_rd_o      (q_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .step_hue_o  (step_hue_o),
    .step_sat_o  (step_sat_o),
    .step_val_o  (step_val_o),
    .last_step_o (last_step_o)
  );

endmodule

// ===== src/hcfs_checker.sv =====
// Port-level checks for the HSV colour fade sequencer, bound to the top level.
// Depends on hcfs_pkg for the step count.
module hcfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] step_hue_o,
  input logic [7:0] step_sat_o,
  input logic [7:0] step_val_o,
  input logic       last_step_o
);

  logic [hcfs_pkg::STEP_W-1:0] taken_q;
  logic [2:0]                  pending_q;
  logic                        in_acc, out_acc, run_done;

  assign in_acc   = push && !full;
  assign out_acc  = pop && !empty;
  assign run_done = out_acc && last_step_o;

  // Count items taken within the current fade
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (run_done) begin
      taken_q <= '0;
    end else if (out_acc) begin
      taken_q <= taken_q + 1'b1;
    end
  end

  // Count targets whose fade is not yet fully delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !run_done) begin
      pending_q <= pending_q + 1'b1;
    end else if (run_done && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A waiting item holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(step_hue_o) && $stable(step_sat_o)
                       && $stable(step_val_o) && $stable(last_step_o))
    else $error("waiting item changed before pop");

  // Last flag exactly on the final item of a fade
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (taken_q == hcfs_pkg::STEPS_L) |-> last_step_o)
    else $error("final item of a fade lacks last_step");

  a_last_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (taken_q != hcfs_pkg::STEPS_L) |-> !last_step_o)
    else $error("last_step before the fade is complete");

  // No item without an accepted target behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != '0))
    else $error("item shown with no target pending");

endmodule

bind hsv_color_fade_sequencer hcfs_checker u_hcfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .step_hue_o  (step_hue_o),
  .step_sat_o  (step_sat_o),
  .step_val_o  (step_val_o),
  .last_step_o (last_step_o)
);

// ===== bench/hsv_color_fade_sequencer_tb.sv =====
// Self-checking bench for the HSV colour fade sequencer: directed and random target colours,
// each expanded into its fade steps by a local predictor and compared item by item.
// Depends on hcfs_pkg and the hsv_color_fade_sequencer top level.
module hsv_color_fade_sequencer_tb;

  localparam int RANDOM_TARGETS = 280;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;

  typedef struct {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_colour_t;

  typedef struct {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic       last;
  } fade_step_t;

  typedef enum int {
    PH_FREE,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } traffic_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] target_hue_i = 8'd0;
  logic [7:0] target_sat_i = 8'd0;
  logic [7:0] target_val_i = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] step_hue_o;
  logic [7:0] step_sat_o;
  logic [7:0] step_val_o;
  logic       last_step_o;

  hsv_colour_t    target_fifo[$];
  fade_step_t     expected_steps[$];
  hsv_colour_t    faded_colour = '{8'd0, 8'd0, 8'd0};
  logic [7:0]     last_queued_hue = 8'd0;
  int             total_targets = 1;
  int             accepted_targets = 0;
  int             error_count = 0;
  int             idle_cycles = 0;
  traffic_phase_e traffic_phase;

  hsv_color_fade_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .target_hue_i(target_hue_i),
    .target_sat_i(target_sat_i),
    .target_val_i(target_val_i),
    .empty       (empty),
    .pop         (pop),
    .step_hue_o  (step_hue_o),
    .step_sat_o  (step_sat_o),
    .step_val_o  (step_val_o),
    .last_step_o (last_step_o)
  );

  always #5 clk_i = ~clk_i;

  // Split the run into four stretches of traffic by progress through the targets
  always_comb begin
    traffic_phase = traffic_phase_e'((accepted_targets * 4) / total_targets);
  end

  // One channel of a fade step: base plus the truncated fraction of the move, modulo 256
  function automatic logic [7:0] blend_channel(logic [7:0] base, int delta, int idx);
    int part;
    int sum;
    part = (delta * idx) / hcfs_pkg::FADE_STEPS;
    sum  = base + part;
    return sum[7:0];
  endfunction

  // Expand an accepted target into its fade steps, then adopt it as the current colour
  function automatic void predict_fade(hsv_colour_t goal);
    int         dh;
    int         ds;
    int         dv;
    int         th;
    int         ch;
    fade_step_t s;
    th = goal.hue;
    ch = faded_colour.hue;
    dh = th - ch;
    ds = int'(goal.sat) - int'(faded_colour.sat);
    dv = int'(goal.val) - int'(faded_colour.val);
    // Take the shorter way round the hue circle
    if (dh > 127) begin
      dh = dh - 256;
    end else if (dh < -128) begin
      dh = dh + 256;
    end
    for (int i = 0; i <= hcfs_pkg::FADE_STEPS; i++) begin
      s.hue  = blend_channel(faded_colour.hue, dh, i);
      s.sat  = blend_channel(faded_colour.sat, ds, i);
      s.val  = blend_channel(faded_colour.val, dv, i);
      s.last = (i == hcfs_pkg::FADE_STEPS);
      expected_steps.push_back(s);
    end
    faded_colour = goal;
  endfunction

  function automatic void queue_target(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    hsv_colour_t c;
    c.hue = h;
    c.sat = s;
    c.val = v;
    target_fifo.push_back(c);
    last_queued_hue = h;
  endfunction

  // Driver: record accepted targets, then load the next one when the slot is free
  always @(posedge clk_i) begin : drive_targets
    hsv_colour_t nxt;
    bit          rest;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_fade('{target_hue_i, target_sat_i, target_val_i});
        accepted_targets <= accepted_targets + 1;
      end
      if (!push || !full) begin
        rest = ((traffic_phase == PH_SEND_GAPS) && ($urandom_range(99) < 47)) ||
               ((traffic_phase == PH_BOTH) && ($urandom_range(99) < 14));
        if (target_fifo.size() != 0 && !rest) begin
          nxt = target_fifo.pop_front();
          push         <= 1'b1;
          target_hue_i <= nxt.hue;
          target_sat_i <= nxt.sat;
          target_val_i <= nxt.val;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped item with the oldest expected step, then pick the next pop
  always @(posedge clk_i) begin : check_steps
    fade_step_t want;
    bit         stall;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected item: hue %0d sat %0d val %0d last %0d",
                 step_hue_o, step_sat_o, step_val_o, last_step_o);
          error_count++;
        end else begin
          want = expected_steps.pop_front();
          if (step_hue_o !== want.hue) begin
            $error("step_hue: expected %0d, actual %0d", want.hue, step_hue_o);
            error_count++;
          end
          if (step_sat_o !== want.sat) begin
            $error("step_sat: expected %0d, actual %0d", want.sat, step_sat_o);
            error_count++;
          end
          if (step_val_o !== want.val) begin
            $error("step_val: expected %0d, actual %0d", want.val, step_val_o);
            error_count++;
          end
          if (last_step_o !== want.last) begin
            $error("last_step: expected %0d, actual %0d", want.last, last_step_o);
            error_count++;
          end
        end
      end
      stall = ((traffic_phase == PH_RECV_STALLS) && ($urandom_range(99) < 47)) ||
              ((traffic_phase == PH_BOTH) && ($urandom_range(99) < 14));
      pop <= !stall;
    end
  end

  // Watchdog: give up when no item moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hsv_color_fade_sequencer_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int         kind;
    logic [7:0] h;
    // Directed: black to black, full swings, hue moves either side of the fold
    queue_target(8'd0,   8'd0,   8'd0);
    queue_target(8'd255, 8'd255, 8'd255);
    queue_target(8'd0,   8'd0,   8'd0);
    queue_target(8'd127, 8'd0,   8'd255);
    queue_target(8'd255, 8'd255, 8'd0);
    queue_target(8'd127, 8'd170, 8'd85);
    queue_target(8'd0,   8'd85,  8'd170);
    queue_target(8'd128, 8'd1,   8'd254);
    queue_target(8'd255, 8'd254, 8'd1);
    queue_target(8'd126, 8'd128, 8'd127);
    queue_target(8'd126, 8'd128, 8'd127);
    queue_target(8'd0,   8'd255, 8'd0);
    queue_target(8'd1,   8'd0,   8'd255);
    queue_target(8'd254, 8'd255, 8'd255);

    // Random: mostly free colours, some near the hue fold, repeats and corners
    for (int n = 0; n < RANDOM_TARGETS; n++) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        queue_target(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind <= 7) begin
        case ($urandom_range(5))
          0: h = last_queued_hue + 8'd127;
          1: h = last_queued_hue + 8'd128;
          2: h = last_queued_hue + 8'd129;
          3: h = last_queued_hue - 8'd127;
          4: h = last_queued_hue - 8'd128;
          default: h = last_queued_hue - 8'd129;
        endcase
        queue_target(h, 8'($urandom), 8'($urandom));
      end else if (kind == 8) begin
        queue_target(last_queued_hue, 8'($urandom), 8'($urandom));
      end else begin
        queue_target($urandom_range(1) ? 8'd255 : 8'd0,
                     $urandom_range(1) ? 8'd255 : 8'd0,
                     $urandom_range(1) ? 8'd255 : 8'd0);
      end
    end
    total_targets = target_fifo.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every target taken and every step seen, then a short tail
    while (target_fifo.size() != 0 || push || expected_steps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("hsv_color_fade_sequencer_tb: PASS");
    end else begin
      $display("hsv_color_fade_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
